>>> rtl/prq_pkg.sv
// Shared types and constants for the process ready queue.
// No dependencies; imported by every module of the block.
package prq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int ID_W   = 16;
    localparam int ST_W   = 2;
    localparam int OP_W   = 3;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 6;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_READY = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;
    localparam logic [OP_W-1:0] OP_PURGE_FG  = 3'd5;
    localparam logic [OP_W-1:0] OP_SET_STATE = 3'd6;

    localparam logic [KIND_W-1:0] KIND_ANSWER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KILLED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNBLOCK = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [ST_W-1:0] PST_READY  = 2'd0;
    localparam logic [ST_W-1:0] PST_KILLED = 2'd1;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] parent;
        logic [ST_W-1:0] st;
        logic            fg;
        logic            wt;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } prq_cmd_t;

    typedef struct packed {
        logic direct;
        logic scan_done;
    } prq_stat_t;

endpackage

>>> rtl/prq_ctrl.sv
// Sequencer for the process ready queue: load, slot walk, answer.
// Depends on prq_pkg.
module prq_ctrl
    import prq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  prq_stat_t stat,
    output prq_cmd_t  cmd,
    output logic      busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.direct || stat.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.finish = (state_reg == S_FIN);
    assign busy       = (state_reg != S_IDLE);

endmodule

>>> rtl/prq_datapath.sv
// Slot memory, walk pointers, counters and result registers of the queue.
// Depends on prq_pkg; driven by prq_ctrl commands.
module prq_datapath
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  prq_cmd_t          cmd,
    output prq_stat_t         stat,
    input  logic [OP_W-1:0]   opcode,
    input  logic [ID_W-1:0]   proc_id,
    input  logic [ID_W-1:0]   parent_id,
    input  logic [ST_W-1:0]   proc_state,
    input  logic              is_foreground,
    input  logic              has_waiter,
    output logic              result_valid,
    output logic [KIND_W-1:0] kind,
    output logic [STAT_W-1:0] status,
    output logic [ID_W-1:0]   out_id,
    output logic [ID_W-1:0]   out_parent,
    output logic [ST_W-1:0]   out_state,
    output logic              out_foreground,
    output logic              out_waiter,
    output logic [CNT_W-1:0]  queue_count,
    output logic              any_ready,
    output logic              last
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    logic [OP_W-1:0] op_reg;
    entry_t          in_reg;
    entry_t          ans_reg;
    entry_t          ans_next;
    logic [CW-1:0]   held_reg, held_next;
    logic [CW-1:0]   ready_reg, ready_next;
    logic [CW-1:0]   rd_idx_reg, wr_idx_reg, drop_reg;
    logic [CW-1:0]   rd_idx_next, wr_idx_next, drop_next;
    logic            ev_valid_reg, hit_reg, stop_reg;
    logic            ev_valid_next, hit_next, stop_next;

    logic            scan_op, issue, ev;
    entry_t          e, wr_entry, mem_wdata;
    logic            drop, report, hit_now, stop_now, id_match;
    logic [KIND_W-1:0] rep_kind;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;

    logic              res_valid_next, last_next, any_ready_next;
    logic [KIND_W-1:0] kind_next;
    logic [STAT_W-1:0] status_next;
    entry_t            res_entry_next;
    logic [CNT_W-1:0]  count_next;

    assign scan_op = (op_reg != OP_APPEND) && (op_reg <= OP_SET_STATE);
    assign issue   = cmd.scan && scan_op && !stop_reg && (rd_idx_reg < held_reg);
    assign ev      = cmd.scan && ev_valid_reg && !stop_reg;
    assign e       = rd_data_reg;
    assign id_match = (e.id == in_reg.id);

    assign stat.direct    = !scan_op;
    assign stat.scan_done = stop_reg || (!ev_valid_reg && (rd_idx_reg >= held_reg));

    // decide what happens to the slot read in the previous cycle
    always_comb
    begin
        drop     = 1'b0;
        report   = 1'b0;
        rep_kind = KIND_KILLED;
        hit_now  = 1'b0;
        stop_now = 1'b0;
        wr_entry = e;
        case (op_reg)
            OP_POP_HEAD:
            begin
                if (!hit_reg)
                begin
                    drop    = 1'b1;
                    hit_now = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!hit_reg && id_match)
                begin
                    drop    = 1'b1;
                    hit_now = 1'b1;
                end
            end
            OP_POP_READY:
            begin
                if (!hit_reg)
                begin
                    if (e.st == PST_READY)
                    begin
                        drop    = 1'b1;
                        hit_now = 1'b1;
                    end
                    else if (e.st == PST_KILLED)
                    begin
                        drop   = 1'b1;
                        report = 1'b1;
                    end
                end
            end
            OP_PURGE_FG:
            begin
                if (e.fg && (e.id > 16'd1))
                begin
                    drop     = 1'b1;
                    report   = e.wt;
                    rep_kind = KIND_UNBLOCK;
                end
            end
            OP_FIND:
            begin
                if (id_match)
                begin
                    hit_now  = 1'b1;
                    stop_now = 1'b1;
                end
            end
            OP_SET_STATE:
            begin
                if (id_match)
                begin
                    hit_now     = 1'b1;
                    stop_now    = 1'b1;
                    wr_entry.st = in_reg.st;
                end
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        held_next      = held_reg;
        ready_next     = ready_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        drop_next      = drop_reg;
        ev_valid_next  = ev_valid_reg;
        hit_next       = hit_reg;
        stop_next      = stop_reg;
        ans_next       = ans_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_idx_reg[IW-1:0];
        mem_wdata      = wr_entry;
        res_valid_next = 1'b0;
        last_next      = 1'b0;
        kind_next      = KIND_ANSWER;
        status_next    = STAT_OK;
        res_entry_next = '0;
        count_next     = '0;
        any_ready_next = 1'b0;

        if (cmd.load)
        begin
            rd_idx_next   = '0;
            wr_idx_next   = '0;
            drop_next     = '0;
            ev_valid_next = 1'b0;
            hit_next      = 1'b0;
            stop_next     = 1'b0;
        end

        if (cmd.scan)
        begin
            ev_valid_next = issue;
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end

        if (ev)
        begin
            if (drop)
            begin
                drop_next = drop_reg + 1'b1;
                if (e.st == PST_READY)
                begin
                    ready_next = ready_reg - 1'b1;
                end
            end
            else
            begin
                mem_we      = 1'b1;
                wr_idx_next = wr_idx_reg + 1'b1;
            end
            if (hit_now)
            begin
                hit_next  = 1'b1;
                stop_next = stop_now;
                ans_next  = wr_entry;
                if (op_reg == OP_SET_STATE)
                begin
                    ready_next = ready_reg - CW'(e.st == PST_READY)
                               + CW'(in_reg.st == PST_READY);
                end
            end
            if (report)
            begin
                res_valid_next = 1'b1;
                kind_next      = rep_kind;
                res_entry_next = e;
                count_next     = CNT_W'(held_reg - drop_next);
                any_ready_next = (ready_next != '0);
            end
        end

        if (cmd.finish)
        begin
            res_valid_next = 1'b1;
            last_next      = 1'b1;
            held_next      = held_reg - drop_reg;
            if (op_reg == OP_APPEND)
            begin
                if (held_reg >= DEPTH_C)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = held_reg[IW-1:0];
                    mem_wdata      = in_reg;
                    held_next      = held_reg + 1'b1;
                    res_entry_next = in_reg;
                    if (in_reg.st == PST_READY)
                    begin
                        ready_next = ready_reg + 1'b1;
                    end
                end
            end
            else if (op_reg == OP_PURGE_FG)
            begin
                status_next = STAT_OK;
            end
            else if (scan_op && hit_reg)
            begin
                res_entry_next = ans_reg;
            end
            else
            begin
                status_next = STAT_EMPTY;
            end
            count_next     = CNT_W'(held_next);
            any_ready_next = (ready_next != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IW-1:0]];
        end
        if (cmd.load)
        begin
            op_reg <= opcode;
            in_reg <= '{id: proc_id, parent: parent_id, st: proc_state,
                        fg: is_foreground, wt: has_waiter};
        end
        ans_reg        <= ans_next;
        kind           <= kind_next;
        status         <= status_next;
        out_id         <= res_entry_next.id;
        out_parent     <= res_entry_next.parent;
        out_state      <= res_entry_next.st;
        out_foreground <= res_entry_next.fg;
        out_waiter     <= res_entry_next.wt;
        queue_count    <= count_next;
        any_ready      <= any_ready_next;
        last           <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            ready_reg    <= '0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            drop_reg     <= '0;
            ev_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            stop_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            held_reg     <= held_next;
            ready_reg    <= ready_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            drop_reg     <= drop_next;
            ev_valid_reg <= ev_valid_next;
            hit_reg      <= hit_next;
            stop_reg     <= stop_next;
            result_valid <= res_valid_next;
        end
    end

endmodule

>>> rtl/process_ready_queue.sv
// Process ready queue, top level. Append and undefined opcodes answer without a slot walk;
// walking operations visit one slot per cycle through the slot memory's single read port,
// with compaction written back behind the read.
// One operation at a time: busy is high from acceptance until the answer cycle.
// Results are strobed by result_valid for one cycle each; the receiver cannot stall.
// Reset empties the queue and clears control; slot contents stay undefined, no clear pass.
module process_ready_queue
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   opcode,
    input  logic [ID_W-1:0]   proc_id,
    input  logic [ID_W-1:0]   parent_id,
    input  logic [ST_W-1:0]   proc_state,
    input  logic              is_foreground,
    input  logic              has_waiter,
    output logic              result_valid,
    output logic [KIND_W-1:0] kind,
    output logic [STAT_W-1:0] status,
    output logic [ID_W-1:0]   out_id,
    output logic [ID_W-1:0]   out_parent,
    output logic [ST_W-1:0]   out_state,
    output logic              out_foreground,
    output logic              out_waiter,
    output logic [CNT_W-1:0]  queue_count,
    output logic              any_ready,
    output logic              last
);

    prq_cmd_t  cmd;
    prq_stat_t stat;

    prq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    prq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .proc_id        (proc_id),
        .parent_id      (parent_id),
        .proc_state     (proc_state),
        .is_foreground  (is_foreground),
        .has_waiter     (has_waiter),
        .result_valid   (result_valid),
        .kind           (kind),
        .status         (status),
        .out_id         (out_id),
        .out_parent     (out_parent),
        .out_state      (out_state),
        .out_foreground (out_foreground),
        .out_waiter     (out_waiter),
        .queue_count    (queue_count),
        .any_ready      (any_ready),
        .last           (last)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_notice_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind != KIND_ANSWER) |-> !last)
        else $error("notice marked as last result");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STAT_FULL) |-> (queue_count == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with queue not full");

    a_last_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> $past(busy))
        else $error("answer without an operation in progress");

endmodule

>>> tb/tb.sv
// Testbench for process_ready_queue: directed and random command sequences.
// Depends on prq_pkg and the process_ready_queue RTL; predicts results in-line.
`timescale 1ns / 1ps

module tb;
    import prq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] pid;
        logic [ID_W-1:0] par;
        logic [ST_W-1:0] st;
        logic            fg;
        logic            wt;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   parent;
        logic [ST_W-1:0]   st;
        logic              fg;
        logic              wt;
        logic [CNT_W-1:0]  count;
        logic              ready;
        logic              last;
    } res_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] proc_id;
    logic [ID_W-1:0] parent_id;
    logic [ST_W-1:0] proc_state;
    logic is_foreground;
    logic has_waiter;
    logic result_valid;
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0] out_id;
    logic [ID_W-1:0] out_parent;
    logic [ST_W-1:0] out_state;
    logic out_foreground;
    logic out_waiter;
    logic [CNT_W-1:0] queue_count;
    logic any_ready;
    logic last;

    process_ready_queue u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .proc_id(proc_id), .parent_id(parent_id),
        .proc_state(proc_state), .is_foreground(is_foreground),
        .has_waiter(has_waiter), .result_valid(result_valid), .kind(kind),
        .status(status), .out_id(out_id), .out_parent(out_parent),
        .out_state(out_state), .out_foreground(out_foreground),
        .out_waiter(out_waiter), .queue_count(queue_count),
        .any_ready(any_ready), .last(last)
    );

    cmd_t   pending_cmds[$];
    res_t   expected_results[$];
    entry_t shadow_q[$];
    int     idle_pct;
    int     errors;
    int     quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit shadow_has_ready();
        foreach (shadow_q[i])
            if (shadow_q[i].st == PST_READY) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_res(logic [KIND_W-1:0] k, logic [STAT_W-1:0] s,
                                     entry_t e, logic l);
        res_t r;
        r.kind = k; r.status = s; r.id = e.id; r.parent = e.parent;
        r.st = e.st; r.fg = e.fg; r.wt = e.wt;
        r.count = CNT_W'(shadow_q.size());
        r.ready = shadow_has_ready();
        r.last = l;
        expected_results.push_back(r);
    endfunction

    // Apply one command to the shadow queue and queue its expected results.
    function automatic void predict_queue_op(cmd_t c);
        entry_t e;
        entry_t zero;
        int f;
        int i;
        zero = '0;
        f = -1;
        case (c.op)
            OP_APPEND:
            begin
                if (shadow_q.size() >= DEPTH)
                    push_res(KIND_ANSWER, STAT_FULL, zero, 1'b1);
                else
                begin
                    e.id = c.pid; e.parent = c.par; e.st = c.st; e.fg = c.fg; e.wt = c.wt;
                    shadow_q.push_back(e);
                    push_res(KIND_ANSWER, STAT_OK, e, 1'b1);
                end
            end
            OP_POP_HEAD, OP_FIND, OP_REMOVE, OP_SET_STATE:
            begin
                if (c.op == OP_POP_HEAD)
                    f = (shadow_q.size() > 0) ? 0 : -1;
                else
                    foreach (shadow_q[j])
                        if (f < 0 && shadow_q[j].id == c.pid) f = j;
                if (f < 0)
                    push_res(KIND_ANSWER, STAT_EMPTY, zero, 1'b1);
                else if (c.op == OP_SET_STATE)
                begin
                    shadow_q[f].st = c.st;
                    push_res(KIND_ANSWER, STAT_OK, shadow_q[f], 1'b1);
                end
                else if (c.op == OP_FIND)
                    push_res(KIND_ANSWER, STAT_OK, shadow_q[f], 1'b1);
                else
                begin
                    e = shadow_q[f];
                    shadow_q.delete(f);
                    push_res(KIND_ANSWER, STAT_OK, e, 1'b1);
                end
            end
            OP_POP_READY:
            begin
                i = 0;
                while (i < shadow_q.size())
                begin
                    e = shadow_q[i];
                    if (e.st == PST_READY)
                    begin
                        shadow_q.delete(i);
                        push_res(KIND_ANSWER, STAT_OK, e, 1'b1);
                        return;
                    end
                    else if (e.st == PST_KILLED)
                    begin
                        shadow_q.delete(i);
                        push_res(KIND_KILLED, STAT_OK, e, 1'b0);
                    end
                    else
                        i++;
                end
                push_res(KIND_ANSWER, STAT_EMPTY, zero, 1'b1);
            end
            OP_PURGE_FG:
            begin
                i = 0;
                while (i < shadow_q.size())
                begin
                    e = shadow_q[i];
                    if (e.fg && e.id > 16'd1)
                    begin
                        shadow_q.delete(i);
                        if (e.wt) push_res(KIND_UNBLOCK, STAT_OK, e, 1'b0);
                    end
                    else
                        i++;
                end
                push_res(KIND_ANSWER, STAT_OK, zero, 1'b1);
            end
            default:
                push_res(KIND_ANSWER, STAT_EMPTY, zero, 1'b1);
        endcase
    endfunction

    // Driver: offer the next pending command when not idling.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start && pending_cmds.size() > 0
                && $urandom_range(99, 0) >= idle_pct)
            begin
                opcode        <= pending_cmds[0].op;
                proc_id       <= pending_cmds[0].pid;
                parent_id     <= pending_cmds[0].par;
                proc_state    <= pending_cmds[0].st;
                is_foreground <= pending_cmds[0].fg;
                has_waiter    <= pending_cmds[0].wt;
                start         <= 1'b1;
            end
        end
    end

    // Acceptance and monitor at the rising edge.
    always @(posedge clk)
    begin
        res_t got;
        res_t exp_r;
        bit   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_queue_op(pending_cmds.pop_front());
                start <= 1'b0;
                moved = 1'b1;
            end
            if (result_valid)
            begin
                moved = 1'b1;
                got = {kind, status, out_id, out_parent, out_state, out_foreground,
                       out_waiter, queue_count, any_ready, last};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                        errors++;
                    end
                end
            end
            if (moved)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cmd_t rand_cmd(int mode);
        cmd_t c;
        int r;
        c.pid = (mode == 0) ? 16'($urandom) : 16'($urandom_range(7, 0));
        if (shadow_q.size() > 0 && $urandom_range(1, 0))
            c.pid = (mode == 0) ? 16'($urandom) : c.pid;
        c.par = 16'($urandom);
        c.st  = 2'($urandom);
        c.fg  = 1'($urandom);
        c.wt  = 1'($urandom);
        r = $urandom_range(99, 0);
        if (r < 35)      c.op = OP_APPEND;
        else if (r < 98) c.op = 3'($urandom_range(6, 1));
        else             c.op = 3'd7;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        cmd_t c;
        start = 1'b0; opcode = '0; proc_id = '0; parent_id = '0;
        proc_state = '0; is_foreground = 1'b0; has_waiter = 1'b0;
        errors = 0; quiet_cycles = 0; idle_pct = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: empty queue, extremes, every opcode, fill to full.
        pending_cmds.push_back({OP_POP_HEAD, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_POP_READY, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({3'd7, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1, 1'b1});
        pending_cmds.push_back({OP_APPEND, 16'hFFFF, 16'hFFFF, 2'd1, 1'b1, 1'b1});
        pending_cmds.push_back({OP_APPEND, 16'd1, 16'd0, 2'd2, 1'b1, 1'b1});
        pending_cmds.push_back({OP_APPEND, 16'd5, 16'd9, 2'd1, 1'b0, 1'b0});
        pending_cmds.push_back({OP_APPEND, 16'd5, 16'd7, 2'd3, 1'b1, 1'b0});
        pending_cmds.push_back({OP_FIND, 16'd5, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_SET_STATE, 16'd5, 16'd0, 2'd2, 1'b0, 1'b0});
        pending_cmds.push_back({OP_FIND, 16'd77, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_POP_READY, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_PURGE_FG, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_REMOVE, 16'd1, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_REMOVE, 16'd1, 16'd0, 2'd0, 1'b0, 1'b0});
        for (int i = 0; i < DEPTH + 1; i++)
            pending_cmds.push_back({OP_APPEND, 16'(i), 16'($urandom), 2'($urandom),
                                    1'($urandom), 1'($urandom)});
        pending_cmds.push_back({OP_POP_READY, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_PURGE_FG, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0});
        pending_cmds.push_back({OP_POP_HEAD, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0});
        wait_drained();

        // Random phases; small pid range most of the time so lookups hit.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 75 : (ph == 2) ? 9 : 0;
            for (int n = 0; n < 43; n++)
            begin
                c = rand_cmd(($urandom_range(9, 0) == 0) ? 0 : 1);
                pending_cmds.push_back(c);
            end
            wait_drained();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end
endmodule
